### rtl/core/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared constants for the truncating double-precision multiplier.
// ----------------------------------------------------------------------------
package dfm_pkg;

  localparam int WORD_W            = 64;
  localparam int FRACTION_BITS_DEF = 52;
  localparam int EXPONENT_BITS_DEF = 11;

endpackage

### rtl/core/dfm_in_if.sv
// ----------------------------------------------------------------------------
// dfm_in_if
// Operand channel: valid/ready handshake carrying two floating-point words.
// ----------------------------------------------------------------------------
interface dfm_in_if;
  import dfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] operand_a;
  logic [WORD_W-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

### rtl/core/dfm_out_if.sv
// ----------------------------------------------------------------------------
// dfm_out_if
// Result channel: valid/ready handshake carrying the product and wrap flag.
// ----------------------------------------------------------------------------
interface dfm_out_if;
  import dfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] product;
  logic              exponent_wrapped;

  modport source (output valid, output product, output exponent_wrapped, input ready);
  modport sink   (input valid, input product, input exponent_wrapped, output ready);
endinterface

### rtl/core/double_float_truncating_multiplier_top.sv
// ----------------------------------------------------------------------------
// double_float_truncating_multiplier_top
// Truncating floating-point multiplier with a three-stage pipeline.
// ----------------------------------------------------------------------------
// Operand pairs enter on in_chan and results leave on out_chan, both with a
// valid/ready handshake; an item moves when valid and ready are both high.
// The pipeline registers the operands, then the four partial products of the
// mantissa multiply, then the normalized result. One item is accepted every
// cycle while the receiver does not stall the pipe; the throughput is set by
// the split mantissa multiplier, which starts a new pair each enabled cycle.
// Each stage advances when it is empty or the stage after it moves, so a
// stalled receiver holds the output register and the stages behind it fill
// up before in_chan.ready drops; empty stages still accept items.
// Synchronous reset clears all stage valid flags; payload registers keep
// whatever they held.
// The product is truncated, never rounded, and the exponent wraps modulo
// its field size with exponent_wrapped set.
// ----------------------------------------------------------------------------
module double_float_truncating_multiplier_top #(
  parameter int FRACTION_BITS = dfm_pkg::FRACTION_BITS_DEF,
  parameter int EXPONENT_BITS = dfm_pkg::EXPONENT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dfm_in_if.sink    in_chan,
  dfm_out_if.source out_chan
);
  import dfm_pkg::*;

  localparam int MANT_W  = FRACTION_BITS + 1;
  localparam int SIGN_P  = FRACTION_BITS + EXPONENT_BITS;
  localparam int ESUM_W  = EXPONENT_BITS + 1;
  localparam int EW      = EXPONENT_BITS + 3;
  localparam logic [EW-1:0] EXP_ADJ = EW'((1 << (EXPONENT_BITS - 1)) - 2);
  localparam logic [EW-1:0] EXP_MAX = EW'((1 << EXPONENT_BITS) - 1);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic [MANT_W-1:0] ma_r, mb_r;
  logic              sign1_r, sign2_r;
  logic [ESUM_W-1:0] esum1_r, esum2_r;
  logic [2*MANT_W-1:0] prod;

  logic [WORD_W-1:0] product_r, product_nxt;
  logic              wrap_r, wrap_nxt;

  logic [MANT_W-1:0]        acc;
  logic [FRACTION_BITS-1:0] frac;
  logic signed [EW-1:0]     exp_val;

  assign adv3 = !v3_r || out_chan.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_chan.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ma_r    <= {1'b1, in_chan.operand_a[FRACTION_BITS-1:0]};
      mb_r    <= {1'b1, in_chan.operand_b[FRACTION_BITS-1:0]};
      sign1_r <= in_chan.operand_a[SIGN_P] ^ in_chan.operand_b[SIGN_P];
      esum1_r <= ESUM_W'(in_chan.operand_a[SIGN_P-1:FRACTION_BITS])
               + ESUM_W'(in_chan.operand_b[SIGN_P-1:FRACTION_BITS]);
    end
    if (adv2) begin
      sign2_r <= sign1_r;
      esum2_r <= esum1_r;
    end
    if (adv3) begin
      product_r <= product_nxt;
      wrap_r    <= wrap_nxt;
    end
  end

  dfm_mant_mul #(
    .MANT_W (MANT_W)
  ) u_mant_mul (
    .clk     (clk),
    .en      (adv2),
    .mant_a  (ma_r),
    .mant_b  (mb_r),
    .product (prod)
  );

  always_comb begin
    acc     = prod[2*MANT_W-1:MANT_W];
    exp_val = EW'(esum2_r) - EXP_ADJ;
    if (acc[FRACTION_BITS]) begin
      frac = acc[FRACTION_BITS-1:0];
    end else begin
      frac    = {acc[FRACTION_BITS-2:0], 1'b0};
      exp_val = exp_val - EW'(1);
    end
    wrap_nxt    = exp_val[EW-1] || (exp_val > $signed(EXP_MAX));
    product_nxt = WORD_W'({sign2_r, exp_val[EXPONENT_BITS-1:0], frac});
  end

  assign out_chan.valid            = v3_r;
  assign out_chan.product          = product_r;
  assign out_chan.exponent_wrapped = wrap_r;
endmodule

### rtl/core/dfm_mant_mul.sv
// ----------------------------------------------------------------------------
// dfm_mant_mul
// Splits two mantissas into halves and registers the four partial products.
// ----------------------------------------------------------------------------
module dfm_mant_mul #(
  parameter int MANT_W = 53
) (
  input  logic                clk,
  input  logic                en,
  input  logic [MANT_W-1:0]   mant_a,
  input  logic [MANT_W-1:0]   mant_b,
  output logic [2*MANT_W-1:0] product
);
  localparam int LO_W = (MANT_W + 1) / 2;
  localparam int HI_W = MANT_W - LO_W;
  localparam int PW   = 2 * MANT_W;

  logic [2*LO_W-1:0]      ll_r;
  logic [LO_W+HI_W-1:0]   lh_r;
  logic [LO_W+HI_W-1:0]   hl_r;
  logic [2*HI_W-1:0]      hh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= mant_a[LO_W-1:0] * mant_b[LO_W-1:0];
      lh_r <= mant_a[LO_W-1:0] * mant_b[MANT_W-1:LO_W];
      hl_r <= mant_a[MANT_W-1:LO_W] * mant_b[LO_W-1:0];
      hh_r <= mant_a[MANT_W-1:LO_W] * mant_b[MANT_W-1:LO_W];
    end
  end

  assign product = PW'(ll_r)
                 + (PW'(lh_r) << LO_W)
                 + (PW'(hl_r) << LO_W)
                 + (PW'(hh_r) << (2 * LO_W));
endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Truncating double multiplier testbench
// Drives operand pairs through the valid/ready operand channel with bursty
// timing and a stalling receiver, predicts each truncated product and wrap
// flag, and compares every result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class product_scoreboard;
  logic [63:0] product_q[$];
  logic        wrapped_q[$];
  int          fail_count;

  function void note_operands(logic [63:0] a, logic [63:0] b);
    logic [105:0] full;
    logic [52:0]  ma;
    logic [52:0]  mb;
    logic [52:0]  mant;
    int           e;
    ma = {1'b1, a[51:0]};
    mb = {1'b1, b[51:0]};
    full = ma * mb;
    mant = full[105:53];
    e = int'(a[62:52]) + int'(b[62:52]) - 1022;
    if (!mant[52]) begin
      mant = mant << 1;
      e = e - 1;
    end
    product_q.push_back({a[63] ^ b[63], e[10:0], mant[51:0]});
    wrapped_q.push_back((e < 0) || (e > 2047));
  endfunction

  function void check_result(logic [63:0] p, logic w);
    logic [63:0] ep;
    logic        ew;
    if (product_q.size() == 0) begin
      $error("product: unexpected result %h", p);
      fail_count++;
      return;
    end
    ep = product_q.pop_front();
    ew = wrapped_q.pop_front();
    if (p !== ep) begin
      $error("product: expected %h actual %h", ep, p);
      fail_count++;
    end
    if (w !== ew) begin
      $error("exponent_wrapped: expected %0b actual %0b", ew, w);
      fail_count++;
    end
  endfunction
endclass

module testbench;
  import dfm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  bit   long_hold = 1'b0;
  product_scoreboard sb = new();

  dfm_in_if  in_chan ();
  dfm_out_if out_chan ();

  double_float_truncating_multiplier_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.operand_a = '0;
    in_chan.operand_b = '0;
    out_chan.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      sb.note_operands(in_chan.operand_a, in_chan.operand_b);
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.product, out_chan.exponent_wrapped);
  end

  // The receiver stalls on its own pattern; a long hold lets the pipe fill.
  initial begin
    int phase;
    phase = 0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (40) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        phase++;
        if ((phase / 300) % 3 == 2)
          out_chan.ready <= 1'b1;
        else
          out_chan.ready <= ($urandom_range(0, 3) != 0);
        @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: w[62:52] = 11'h000;
      1: w[62:52] = 11'h7ff;
      2: w[62:52] = 11'(32'h3ff + $urandom_range(0, 20) - 32'd10);
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_pair(logic [63:0] a, logic [63:0] b);
    in_chan.valid <= 1'b1;
    in_chan.operand_a <= a;
    in_chan.operand_b <= b;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic idle_cycles(int n);
    in_chan.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.product_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] edge_vals[8];
    int sent;
    int burst;
    edge_vals = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
                  64'h7ff0_0000_0000_0000, 64'h000f_ffff_ffff_ffff,
                  64'h8000_0000_0000_0001, 64'h3fff_ffff_ffff_ffff,
                  64'hc00f_ffff_ffff_ffff};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 8; i++)
      for (int j = i; j < 8; j += 3)
        send_pair(edge_vals[i], edge_vals[j]);
    send_pair(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
    send_pair(64'h4000_0000_0000_0000, 64'h3fe0_0000_0000_0000);
    wait_drained();
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++)
      send_pair(random_word(), random_word());
    wait_drained();
    sent = 0;
    while (sent < 1950) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++)
        send_pair(random_word(), random_word());
      sent += burst;
      if ($urandom_range(0, 2) == 0)
        idle_cycles($urandom_range(1, 6));
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.product_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
